// File: rtl/adi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// adi_pkg: arm/disarm interlock shared definitions
// Types, thresholds, mode codes and register indexes for the interlock.
// ---------------------------------------------------------------------------
package adi_pkg;

  localparam int TIME_BITS_DEF = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ARMING_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUND_FRAME = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_HOLD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DISARM_HOLD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd4;

  // arming source codes
  localparam logic [3:0] MODE_ALWAYS_DISARMED = 4'd0;
  localparam logic [3:0] MODE_ALWAYS_ARMED    = 4'd1;
  localparam logic [3:0] MODE_ROLL_LEFT       = 4'd2;
  localparam logic [3:0] MODE_ROLL_RIGHT      = 4'd3;
  localparam logic [3:0] MODE_PITCH_FWD       = 4'd4;
  localparam logic [3:0] MODE_PITCH_AFT       = 4'd5;
  localparam logic [3:0] MODE_YAW_LEFT        = 4'd6;
  localparam logic [3:0] MODE_YAW_RIGHT       = 4'd7;
  localparam logic [3:0] MODE_SWITCH          = 4'd8;
  localparam logic [3:0] MODE_NONE_SEEN       = 4'd15;

  // reset values
  localparam logic [15:0] ARM_HOLD_RST     = 16'd1000;
  localparam logic [15:0] DISARM_HOLD_RST  = 16'd1000;
  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd30000;

  // Q1.14 thresholds: 0.8, 0.2, 0.01 (integer approximations)
  localparam logic signed [16:0] TH_STICK    = 17'sd13108;
  localparam logic signed [16:0] TH_SWITCH   = 17'sd3277;
  localparam logic signed [16:0] GROUND_IDLE = 17'sd163;
  localparam logic signed [16:0] LEVEL_MAX   = 17'sd32767;

  typedef enum logic [2:0] {
    ST_DISARMED       = 3'd0,
    ST_ARMING         = 3'd1,
    ST_ARMED          = 3'd2,
    ST_DISARM_MANUAL  = 3'd3,
    ST_DISARM_TIMEOUT = 3'd4
  } state_t;

  typedef enum logic [1:0] {
    STAT_DISARMED = 2'd0,
    STAT_ARMING   = 2'd1,
    STAT_ARMED    = 2'd2
  } status_t;

  typedef struct packed {
    logic        reinit;
    logic [31:0] now_ms;
    logic [15:0] throttle;
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic [15:0] switch_level;
    logic        forced_disarm;
    logic        ok_to_arm;
    logic        follower_engaged;
  } item_t;

  typedef struct packed {
    logic [3:0]  arming_mode;
    logic        ground_frame;
    logic [15:0] arm_hold_ms;
    logic [15:0] disarm_hold_ms;
    logic [15:0] idle_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic        low;
    logic        arm_edge;
    logic        disarm_edge;
    logic [15:0] level_sat;
  } gest_t;

  typedef struct packed {
    status_t armed_status;
    state_t  machine_state;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/adi_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// adi_if: interlock channel interfaces
// Valid/ready channels for the tick word and the result word.
// ---------------------------------------------------------------------------
interface adi_tick_if;
  logic        valid;
  logic        ready;
  logic        reinit;
  logic [31:0] now_ms;
  logic signed [15:0] throttle;
  logic signed [15:0] roll;
  logic signed [15:0] pitch;
  logic signed [15:0] yaw;
  logic signed [15:0] switch_level;
  logic        forced_disarm;
  logic        ok_to_arm;
  logic        follower_engaged;

  modport source (output valid, reinit, now_ms, throttle, roll, pitch, yaw, switch_level,
                  forced_disarm, ok_to_arm, follower_engaged, input ready);
  modport sink (input valid, reinit, now_ms, throttle, roll, pitch, yaw, switch_level,
                forced_disarm, ok_to_arm, follower_engaged, output ready);
endinterface

interface adi_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] armed_status;
  logic [2:0] machine_state;

  modport source (output valid, armed_status, machine_state, input ready);
  modport sink (input valid, armed_status, machine_state, output ready);
endinterface
`default_nettype wire

// File: rtl/adi_gesture.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// adi_gesture: arming level select and edge detect
// Picks the arming level, finds low throttle and threshold crossings.
// ---------------------------------------------------------------------------
module adi_gesture
  import adi_pkg::*;
(
  input  item_t       item,
  input  cfg_t        cfg,
  input  logic [15:0] prev_level,
  output gest_t       gest
);

  logic signed [16:0] thr_x, roll_x, pitch_x, yaw_x, sw_x, prev_x;
  logic signed [16:0] level, th;
  logic               is_switch, low, arm_e, dis_e;

  assign thr_x   = $signed({item.throttle[15], item.throttle});
  assign roll_x  = $signed({item.roll[15], item.roll});
  assign pitch_x = $signed({item.pitch[15], item.pitch});
  assign yaw_x   = $signed({item.yaw[15], item.yaw});
  assign sw_x    = $signed({item.switch_level[15], item.switch_level});
  assign prev_x  = $signed({prev_level[15], prev_level});

  assign is_switch = (cfg.arming_mode == MODE_SWITCH);
  assign th        = is_switch ? TH_SWITCH : TH_STICK;

  always_comb begin
    if (cfg.ground_frame) begin
      low = (thr_x <= GROUND_IDLE) && (thr_x >= -GROUND_IDLE);
    end else begin
      low = item.throttle[15];
    end
    if (is_switch && (sw_x <= -TH_SWITCH)) begin
      low = 1'b1;
    end
  end

  always_comb begin
    case (cfg.arming_mode)
      MODE_ROLL_LEFT:  level = roll_x;
      MODE_ROLL_RIGHT: level = -roll_x;
      MODE_PITCH_FWD:  level = pitch_x;
      MODE_PITCH_AFT:  level = -pitch_x;
      MODE_YAW_LEFT:   level = yaw_x;
      MODE_YAW_RIGHT:  level = -yaw_x;
      MODE_SWITCH:     level = -sw_x;
      default:         level = '0;
    endcase
  end

  assign arm_e = (level <= -th) && (prev_x > -th);
  assign dis_e = !arm_e && (level >= th) && (prev_x < th);

  assign gest.low         = low;
  assign gest.arm_edge    = arm_e;
  assign gest.disarm_edge = dis_e;
  // negated full-scale stick saturates to the positive limit
  assign gest.level_sat   = (level > LEVEL_MAX) ? LEVEL_MAX[15:0] : level[15:0];

endmodule
`default_nettype wire

// File: rtl/adi_fsm.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// adi_fsm: arm state machine
// Holds state, status, hold timer start and edge history; updates per word.
// ---------------------------------------------------------------------------
module adi_fsm
  import adi_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  item_t       item,
  input  cfg_t        cfg,
  input  gest_t       gest,
  output logic [15:0] prev_level,
  output res_t        res_next
);

  state_t                 arm_state, arm_state_next, s0;
  status_t                status, status_next, st0;
  logic [TIME_BITS-1:0]   seq_start, seq_start_next, now_t, elapsed;
  logic [15:0]            prior_level, prior_level_next;
  logic [3:0]             prior_mode, prior_mode_next;

  assign s0    = item.reinit ? ST_DISARMED : arm_state;
  assign st0   = item.reinit ? STAT_DISARMED : status;
  assign now_t = TIME_BITS'(item.now_ms);
  assign elapsed = now_t - seq_start;

  // history is void after a mode change or while in a transient state
  assign prev_level = ((prior_mode != cfg.arming_mode) ||
                       ((s0 != ST_DISARMED) && (s0 != ST_ARMED))) ? 16'd0 : prior_level;

  always_comb begin
    arm_state_next   = s0;
    status_next      = st0;
    seq_start_next   = seq_start;
    prior_level_next = prior_level;
    prior_mode_next  = prior_mode;
    if (item.forced_disarm) begin
      arm_state_next = ST_DISARMED;
      status_next    = STAT_DISARMED;
    end else if (cfg.arming_mode == MODE_ALWAYS_DISARMED) begin
      status_next = STAT_DISARMED;
    end else if (!gest.low) begin
      if (s0 == ST_DISARM_MANUAL || s0 == ST_DISARM_TIMEOUT) begin
        arm_state_next = ST_ARMED;
      end else if (s0 == ST_ARMING) begin
        arm_state_next = ST_DISARMED;
      end
    end else if (cfg.arming_mode == MODE_ALWAYS_ARMED) begin
      status_next = STAT_ARMED;
    end else begin
      prior_mode_next  = cfg.arming_mode;
      prior_level_next = gest.level_sat;
      case (s0)
        ST_DISARMED: begin
          status_next = STAT_DISARMED;
          if (gest.arm_edge && item.ok_to_arm) begin
            seq_start_next = now_t;
            arm_state_next = ST_ARMING;
          end
        end
        ST_ARMING: begin
          status_next = STAT_ARMING;
          if (gest.arm_edge && (elapsed > TIME_BITS'(cfg.arm_hold_ms))) begin
            arm_state_next = ST_ARMED;
          end else if (!gest.arm_edge) begin
            arm_state_next = ST_DISARMED;
          end
        end
        ST_ARMED: begin
          seq_start_next = now_t;
          arm_state_next = ST_DISARM_TIMEOUT;
          status_next    = STAT_ARMED;
        end
        ST_DISARM_TIMEOUT: begin
          // follower engagement restarts the timer and blocks the timeout for this word
          if (item.follower_engaged) begin
            seq_start_next = now_t;
          end
          if (!item.follower_engaged && (cfg.idle_timeout_ms != 16'd0) &&
              (elapsed > TIME_BITS'(cfg.idle_timeout_ms))) begin
            arm_state_next = ST_DISARMED;
          end
          if (gest.disarm_edge) begin
            seq_start_next = now_t;
            arm_state_next = ST_DISARM_MANUAL;
          end
        end
        ST_DISARM_MANUAL: begin
          if (gest.disarm_edge && (elapsed > TIME_BITS'(cfg.disarm_hold_ms))) begin
            arm_state_next = ST_DISARMED;
          end else if (!gest.disarm_edge) begin
            arm_state_next = ST_ARMED;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arm_state   <= ST_DISARMED;
      status      <= STAT_DISARMED;
      seq_start   <= '0;
      prior_level <= '0;
      prior_mode  <= MODE_NONE_SEEN;
    end else if (en) begin
      arm_state   <= arm_state_next;
      status      <= status_next;
      seq_start   <= seq_start_next;
      prior_level <= prior_level_next;
      prior_mode  <= prior_mode_next;
    end
  end

  assign res_next.armed_status  = status_next;
  assign res_next.machine_state = arm_state_next;

  a_forced_disarm: assert property (@(posedge clk) disable iff (rst)
    en && item.forced_disarm |=> (arm_state == ST_DISARMED) && (status == STAT_DISARMED))
    else $error("forced disarm did not clear state and status");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(arm_state) && $stable(status) && $stable(seq_start))
    else $error("state changed without a word");

  a_arm_needs_ok: assert property (@(posedge clk) disable iff (rst)
    en && !item.ok_to_arm && (arm_state != ST_ARMING) |=> arm_state != ST_ARMING)
    else $error("arming entered without permission");

  a_reinit_disabled: assert property (@(posedge clk) disable iff (rst)
    en && item.reinit && (cfg.arming_mode == MODE_ALWAYS_DISARMED)
    |=> (arm_state == ST_DISARMED) && (status == STAT_DISARMED))
    else $error("reinit did not disarm");

endmodule
`default_nettype wire

// File: rtl/arm_disarm_interlock_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Tick words pass the input register, then the result register once it is free.
// One word per cycle while results are taken; the state update is a single combinational pass.
// A waiting result does not block the next tick word while the input register is free.
// Reset (rst, synchronous): disarmed state and status, timer start and history cleared,
// mode history set to none seen, configuration registers to their defaults.
// ---------------------------------------------------------------------------
// arm_disarm_interlock_top: arm/disarm interlock
// Configuration registers, input and result registers around the arm FSM.
// ---------------------------------------------------------------------------
module arm_disarm_interlock_top
  import adi_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  adi_tick_if.sink              tick,
  adi_result_if.source          result
);

  cfg_t        cfg;
  item_t       item_q;
  logic        in_vld, out_vld, adv;
  res_t        res_next, res_q;
  gest_t       gest;
  logic [15:0] prev_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arming_mode     <= MODE_ALWAYS_DISARMED;
      cfg.ground_frame    <= 1'b0;
      cfg.arm_hold_ms     <= ARM_HOLD_RST;
      cfg.disarm_hold_ms  <= DISARM_HOLD_RST;
      cfg.idle_timeout_ms <= IDLE_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ARMING_MODE:  cfg.arming_mode     <= cfg_data[3:0];
        REG_GROUND_FRAME: cfg.ground_frame    <= cfg_data[0];
        REG_ARM_HOLD:     cfg.arm_hold_ms     <= cfg_data;
        REG_DISARM_HOLD:  cfg.disarm_hold_ms  <= cfg_data;
        REG_IDLE_TIMEOUT: cfg.idle_timeout_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign adv        = in_vld && (!out_vld || result.ready);
  assign tick.ready = !in_vld || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (tick.ready) begin
      in_vld <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      item_q.reinit           <= tick.reinit;
      item_q.now_ms           <= tick.now_ms;
      item_q.throttle         <= tick.throttle;
      item_q.roll             <= tick.roll;
      item_q.pitch            <= tick.pitch;
      item_q.yaw              <= tick.yaw;
      item_q.switch_level     <= tick.switch_level;
      item_q.forced_disarm    <= tick.forced_disarm;
      item_q.ok_to_arm        <= tick.ok_to_arm;
      item_q.follower_engaged <= tick.follower_engaged;
    end
  end

  adi_gesture u_gesture (
    .item       (item_q),
    .cfg        (cfg),
    .prev_level (prev_level),
    .gest       (gest)
  );

  adi_fsm #(
    .TIME_BITS (TIME_BITS)
  ) u_fsm (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .item       (item_q),
    .cfg        (cfg),
    .gest       (gest),
    .prev_level (prev_level),
    .res_next   (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= 1'b1;
    end else if (result.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_q <= res_next;
    end
  end

  assign result.valid         = out_vld;
  assign result.armed_status  = res_q.armed_status;
  assign result.machine_state = res_q.machine_state;

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: arm/disarm interlock testbench
// Drives tick words through a short directed table and then phases of random
// gesture sequences under changing register settings. Each result word is
// checked against a typed table value or a cycle-free model of the arm FSM.
// ---------------------------------------------------------------------------
module tb_top;
  import adi_pkg::*;

  localparam int STICK_TH  = 13108;  // 0.8 in Q1.14
  localparam int SWITCH_TH = 3277;   // 0.2 in Q1.14
  localparam int IDLE_BAND = 163;    // |throttle| < 0.01
  localparam int IDLE_PCT  = 13;
  localparam int PHASES    = 9;
  localparam int PHASE_LEN = 90;
  localparam logic [3:0] MODE_SPARE = 4'd12;  // unused mode, no gestures

  typedef struct {
    logic               reinit;
    logic [31:0]        now_ms;
    logic signed [15:0] throttle;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [15:0] switch_level;
    logic               forced;
    logic               ok;
    logic               follow;
  } tick_t;

  typedef struct {
    bit    is_cfg;
    cfg_t  cfg;
    tick_t tk;
    bit    typed;
    res_t  exp;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  adi_tick_if   tick_ch();
  adi_result_if res_ch();

  arm_disarm_interlock_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .tick     (tick_ch),
    .result   (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // interlock model state
  cfg_t        cfg;
  state_t      fsm_st;
  status_t     held_stat;
  logic [31:0] seq_start;
  int          last_level;
  logic [3:0]  last_mode;

  res_t        due_results[$];
  plan_row_t   plan[$];
  int          mismatches = 0;
  bit          calm = 1'b0;
  logic [31:0] sim_ms;
  int          gest_level = 0;
  res_t        got_want;

  function automatic res_t step_interlock(input tick_t t);
    logic low, arm_e, dis_e;
    int lvl, prev, th;
    res_t r;
    if (t.reinit) begin
      held_stat = STAT_DISARMED;
      fsm_st = ST_DISARMED;
    end
    if (cfg.ground_frame) low = (t.throttle <= IDLE_BAND) && (t.throttle >= -IDLE_BAND);
    else low = t.throttle < 0;
    if (cfg.arming_mode == MODE_SWITCH && t.switch_level <= -SWITCH_TH) low = 1'b1;

    if (t.forced) begin
      fsm_st = ST_DISARMED;
      held_stat = STAT_DISARMED;
    end else if (cfg.arming_mode == MODE_ALWAYS_DISARMED) begin
      held_stat = STAT_DISARMED;
    end else if (!low) begin
      if (fsm_st == ST_DISARM_MANUAL || fsm_st == ST_DISARM_TIMEOUT) fsm_st = ST_ARMED;
      else if (fsm_st == ST_ARMING) fsm_st = ST_DISARMED;
    end else if (cfg.arming_mode == MODE_ALWAYS_ARMED) begin
      held_stat = STAT_ARMED;
    end else begin
      case (cfg.arming_mode)
        MODE_ROLL_LEFT:  lvl = int'(t.roll);
        MODE_ROLL_RIGHT: lvl = -int'(t.roll);
        MODE_PITCH_FWD:  lvl = int'(t.pitch);
        MODE_PITCH_AFT:  lvl = -int'(t.pitch);
        MODE_YAW_LEFT:   lvl = int'(t.yaw);
        MODE_YAW_RIGHT:  lvl = -int'(t.yaw);
        MODE_SWITCH:     lvl = -int'(t.switch_level);
        default:         lvl = 0;
      endcase
      if (last_mode != cfg.arming_mode) begin
        last_mode = cfg.arming_mode;
        last_level = 0;
      end
      // transient states see a released stick
      if (fsm_st != ST_DISARMED && fsm_st != ST_ARMED) last_level = 0;
      prev = last_level;
      th = (cfg.arming_mode == MODE_SWITCH) ? SWITCH_TH : STICK_TH;
      arm_e = (lvl <= -th) && (prev > -th);
      dis_e = !arm_e && (lvl >= th) && (prev < th);
      last_level = (lvl > 32767) ? 32767 : lvl;

      case (fsm_st)
        ST_DISARMED: begin
          held_stat = STAT_DISARMED;
          if (arm_e && t.ok) begin
            seq_start = t.now_ms;
            fsm_st = ST_ARMING;
          end
        end
        ST_ARMING: begin
          held_stat = STAT_ARMING;
          if (arm_e && 32'(t.now_ms - seq_start) > 32'(cfg.arm_hold_ms)) fsm_st = ST_ARMED;
          else if (!arm_e) fsm_st = ST_DISARMED;
        end
        ST_ARMED: begin
          seq_start = t.now_ms;
          fsm_st = ST_DISARM_TIMEOUT;
          held_stat = STAT_ARMED;
        end
        ST_DISARM_TIMEOUT: begin
          if (t.follow) seq_start = t.now_ms;
          if (cfg.idle_timeout_ms != 0 &&
              32'(t.now_ms - seq_start) > 32'(cfg.idle_timeout_ms)) fsm_st = ST_DISARMED;
          if (dis_e) begin
            seq_start = t.now_ms;
            fsm_st = ST_DISARM_MANUAL;
          end
        end
        ST_DISARM_MANUAL: begin
          if (dis_e && 32'(t.now_ms - seq_start) > 32'(cfg.disarm_hold_ms)) fsm_st = ST_DISARMED;
          else if (!dis_e) fsm_st = ST_ARMED;
        end
        default: ;
      endcase
    end
    r.armed_status = held_stat;
    r.machine_state = fsm_st;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [3:0] m, input logic gf,
                                        input logic [15:0] ah, input logic [15:0] dh,
                                        input logic [15:0] it);
    plan_row_t r;
    r.is_cfg = 1'b1;
    r.cfg = '{m, gf, ah, dh, it};
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic plan_row_t tick_row(input logic ri, input logic [31:0] now,
                                         input int thr, input int rl, input int pt,
                                         input int yw, input int sw, input logic fd,
                                         input logic ok, input logic fl, input bit typed,
                                         input status_t s, input state_t q);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.tk = '{ri, now, 16'(thr), 16'(rl), 16'(pt), 16'(yw), 16'(sw), fd, ok, fl};
    r.typed = typed;
    r.exp.armed_status = s;
    r.exp.machine_state = q;
    return r;
  endfunction

  function automatic logic [15:0] pick_ms(input int lo, input int hi);
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic signed [15:0] stick_val(input bit noisy);
    if (noisy) return 16'($urandom());
    return 16'(int'($urandom_range(32768)) - 16384);
  endfunction

  function automatic tick_t next_gesture_tick();
    tick_t t;
    int r, th, thr;
    bit noisy;
    th = (cfg.arming_mode == MODE_SWITCH) ? SWITCH_TH : STICK_TH;
    r = $urandom_range(99);
    if (r < 88) sim_ms += $urandom_range(150);
    else if (r < 95) sim_ms += $urandom_range(70000, 60000);
    else sim_ms = $urandom();

    // the gesture level persists so that holds can complete
    if ($urandom_range(99) < 30) begin
      r = $urandom_range(99);
      if (r < 40) gest_level = -int'($urandom_range(16384, th));
      else if (r < 65) gest_level = int'($urandom_range(16384, th));
      else if (r < 75) begin
        case ($urandom_range(3))
          0: gest_level = th;
          1: gest_level = -th;
          2: gest_level = th - 1;
          default: gest_level = -th + 1;
        endcase
      end else if (r < 90) gest_level = int'($urandom_range(2 * th - 2)) - th + 1;
      else gest_level = int'($signed(16'($urandom())));
    end

    noisy = ($urandom_range(99) < 8);
    t.now_ms = sim_ms;
    t.roll = stick_val(noisy);
    t.pitch = stick_val(noisy);
    t.yaw = stick_val(noisy);
    t.switch_level = stick_val(noisy);
    t.throttle = stick_val(noisy);
    if (!noisy) begin
      case (cfg.arming_mode)
        MODE_ROLL_LEFT:  t.roll = 16'(gest_level);
        MODE_ROLL_RIGHT: t.roll = 16'(-gest_level);
        MODE_PITCH_FWD:  t.pitch = 16'(gest_level);
        MODE_PITCH_AFT:  t.pitch = 16'(-gest_level);
        MODE_YAW_LEFT:   t.yaw = 16'(gest_level);
        MODE_YAW_RIGHT:  t.yaw = 16'(-gest_level);
        MODE_SWITCH:     t.switch_level = 16'(-gest_level);
        default: ;
      endcase
      if ($urandom_range(99) < 85) begin
        if (cfg.ground_frame) thr = int'($urandom_range(2 * IDLE_BAND)) - IDLE_BAND;
        else thr = -int'($urandom_range(16384, 1));
      end else if (cfg.ground_frame) begin
        thr = int'($urandom_range(16384, IDLE_BAND + 1));
        if ($urandom_range(1)) thr = -thr;
      end else begin
        thr = int'($urandom_range(16384));
      end
      t.throttle = 16'(thr);
    end
    t.reinit = noisy ? 1'($urandom()) : ($urandom_range(99) < 2);
    t.forced = noisy ? 1'($urandom()) : ($urandom_range(99) < 2);
    t.ok = noisy ? 1'($urandom()) : ($urandom_range(99) < 90);
    t.follow = noisy ? 1'($urandom()) : ($urandom_range(99) < 15);
    return t;
  endfunction

  // Entered and left at a falling edge; valid drops for random idle gaps unless calm, then stays high until taken.
  task automatic send_tick(input tick_t t, input bit typed, input res_t exp);
    res_t want;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      tick_ch.valid <= 1'b0;
      @(negedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.reinit <= t.reinit;
    tick_ch.now_ms <= t.now_ms;
    tick_ch.throttle <= t.throttle;
    tick_ch.roll <= t.roll;
    tick_ch.pitch <= t.pitch;
    tick_ch.yaw <= t.yaw;
    tick_ch.switch_level <= t.switch_level;
    tick_ch.forced_disarm <= t.forced;
    tick_ch.ok_to_arm <= t.ok;
    tick_ch.follower_engaged <= t.follow;
    do @(posedge clk); while (!tick_ch.ready);
    want = step_interlock(t);
    if (typed) want = exp;
    due_results.push_back(want);
    @(negedge clk);
  endtask

  task automatic drain();
    tick_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic reconfigure(input cfg_t c);
    drain();
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      case (i)
        0: begin cfg_idx <= REG_ARMING_MODE;  cfg_data <= 16'(c.arming_mode); end
        1: begin cfg_idx <= REG_GROUND_FRAME; cfg_data <= 16'(c.ground_frame); end
        2: begin cfg_idx <= REG_ARM_HOLD;     cfg_data <= c.arm_hold_ms; end
        3: begin cfg_idx <= REG_DISARM_HOLD;  cfg_data <= c.disarm_hold_ms; end
        default: begin cfg_idx <= REG_IDLE_TIMEOUT; cfg_data <= c.idle_timeout_ms; end
      endcase
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    cfg = c;
  endtask

  // result sink
  always @(negedge clk) res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result word status %0d state %0d", $time,
                 res_ch.armed_status, res_ch.machine_state);
        mismatches++;
      end else begin
        got_want = due_results.pop_front();
        if (res_ch.armed_status !== got_want.armed_status) begin
          $display("%0t: armed_status expected %0d got %0d", $time,
                   got_want.armed_status, res_ch.armed_status);
          mismatches++;
        end
        if (res_ch.machine_state !== got_want.machine_state) begin
          $display("%0t: machine_state expected %0d got %0d", $time,
                   got_want.machine_state, res_ch.machine_state);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    cfg_t c;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    tick_ch.valid = 1'b0;
    tick_ch.reinit = 1'b0;
    tick_ch.now_ms = '0;
    tick_ch.throttle = '0;
    tick_ch.roll = '0;
    tick_ch.pitch = '0;
    tick_ch.yaw = '0;
    tick_ch.switch_level = '0;
    tick_ch.forced_disarm = 1'b0;
    tick_ch.ok_to_arm = 1'b0;
    tick_ch.follower_engaged = 1'b0;
    res_ch.ready = 1'b0;

    cfg = '{MODE_ALWAYS_DISARMED, 1'b0, 16'd1000, 16'd1000, 16'd30000};
    fsm_st = ST_DISARMED;
    held_stat = STAT_DISARMED;
    seq_start = '0;
    last_level = 0;
    last_mode = MODE_NONE_SEEN;

    // always disarmed after reset, then always armed until a forced disarm
    plan.push_back(tick_row(0, 0, -16384, -16384, 0, 0, 0, 0, 1, 0, 1,
                            STAT_DISARMED, ST_DISARMED));
    plan.push_back(cfg_row(MODE_ALWAYS_ARMED, 1'b0, 16'd0, 16'd0, 16'd0));
    plan.push_back(tick_row(0, 10, -1, 0, 0, 0, 0, 0, 1, 0, 1, STAT_ARMED, ST_DISARMED));
    plan.push_back(tick_row(0, 20, 16384, 0, 0, 0, 0, 0, 1, 0, 1, STAT_ARMED, ST_DISARMED));
    plan.push_back(tick_row(0, 30, -16384, 0, 0, 0, 0, 1, 1, 0, 1,
                            STAT_DISARMED, ST_DISARMED));
    // arm by roll, idle timeout, then arm again and disarm by hand
    plan.push_back(cfg_row(MODE_ROLL_LEFT, 1'b0, 16'd100, 16'd100, 16'd500));
    plan.push_back(tick_row(0, 1000, -100, -13108, 0, 0, 0, 0, 1, 0, 0,
                            STAT_DISARMED, ST_DISARMED));
    plan.push_back(tick_row(0, 1050, -100, -16384, 0, 0, 0, 0, 1, 0, 0,
                            STAT_DISARMED, ST_DISARMED));
    plan.push_back(tick_row(0, 1101, -100, -13108, 0, 0, 0, 0, 1, 0, 0,
                            STAT_DISARMED, ST_DISARMED));
    plan.push_back(tick_row(0, 1102, -100, 0, 0, 0, 0, 0, 1, 1, 0, STAT_DISARMED, ST_DISARMED));
    plan.push_back(tick_row(0, 1700, -100, 0, 0, 0, 0, 0, 1, 0, 0, STAT_DISARMED, ST_DISARMED));
    plan.push_back(tick_row(0, 1800, -100, -16384, 0, 0, 0, 0, 1, 0, 0,
                            STAT_DISARMED, ST_DISARMED));
    plan.push_back(tick_row(0, 1901, -100, -16384, 0, 0, 0, 0, 1, 0, 0,
                            STAT_DISARMED, ST_DISARMED));
    plan.push_back(tick_row(0, 1902, -100, 13108, 0, 0, 0, 0, 1, 0, 0,
                            STAT_DISARMED, ST_DISARMED));
    plan.push_back(tick_row(0, 1950, -100, 16384, 0, 0, 0, 0, 1, 0, 0,
                            STAT_DISARMED, ST_DISARMED));
    plan.push_back(tick_row(0, 2051, -100, 16384, 0, 0, 0, 0, 1, 0, 0,
                            STAT_DISARMED, ST_DISARMED));
    // switch arming on a ground frame across the time wrap
    plan.push_back(cfg_row(MODE_SWITCH, 1'b1, 16'd0, 16'hFFFF, 16'hFFFF));
    plan.push_back(tick_row(0, 32'hFFFF_FFFF, 163, 0, 0, 0, 16384, 0, 1, 0, 0,
                            STAT_DISARMED, ST_DISARMED));
    plan.push_back(tick_row(0, 0, -163, 0, 0, 0, 3277, 0, 1, 0, 0, STAT_DISARMED, ST_DISARMED));
    plan.push_back(tick_row(0, 5, 16384, 0, 0, 0, -3277, 0, 1, 0, 0,
                            STAT_DISARMED, ST_DISARMED));
    plan.push_back(tick_row(1, 6, 164, 0, 0, 0, 0, 0, 1, 0, 1, STAT_DISARMED, ST_DISARMED));
    // negated full-scale stick saturates in the history
    plan.push_back(cfg_row(MODE_YAW_RIGHT, 1'b0, 16'hFFFF, 16'd0, 16'd0));
    plan.push_back(tick_row(0, 100, -16384, 0, 0, -32768, 0, 0, 1, 0, 0,
                            STAT_DISARMED, ST_DISARMED));
    plan.push_back(tick_row(0, 200, -16384, 0, 0, 16384, 0, 0, 0, 0, 0,
                            STAT_DISARMED, ST_DISARMED));
    // unused mode never gestures
    plan.push_back(cfg_row(MODE_SPARE, 1'b1, 16'd1, 16'd1, 16'd1));
    plan.push_back(tick_row(0, 300, 0, -16384, -16384, -16384, 16384, 0, 1, 1, 0,
                            STAT_DISARMED, ST_DISARMED));
    plan.push_back(tick_row(0, 400, -32768, 32767, 32767, 32767, -32768, 0, 1, 0, 0,
                            STAT_DISARMED, ST_DISARMED));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) reconfigure(plan[i].cfg);
      else send_tick(plan[i].tk, plan[i].typed, plan[i].exp);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 7) c.arming_mode = MODE_ROLL_LEFT + 4'(ph);
      else if (ph == 7) c.arming_mode = 4'($urandom_range(15));
      else c.arming_mode = MODE_SWITCH;
      c.ground_frame = 1'($urandom_range(1));
      c.arm_hold_ms = pick_ms(20, 300);
      c.disarm_hold_ms = pick_ms(20, 300);
      c.idle_timeout_ms = pick_ms(100, 1000);
      reconfigure(c);
      calm = (ph == 3);
      if ($urandom_range(3) == 0) sim_ms = 32'hFFFF_FF00 + $urandom_range(255);
      else sim_ms = $urandom();
      for (int k = 0; k < PHASE_LEN; k++) send_tick(next_gesture_tick(), 1'b0, '0);
    end
    calm = 1'b0;

    drain();
    repeat (4) @(negedge clk);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: arm_disarm_interlock_top.f
rtl/adi_pkg.sv
rtl/adi_if.sv
rtl/adi_gesture.sv
rtl/adi_fsm.sv
rtl/arm_disarm_interlock_top.sv
sim/tb_top.sv
